FILE: rtl/cmab_pkg.sv
// shared constants, codes and helper functions of the colormap alpha blend block
package cmab_pkg;

    localparam int MAP_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [8:0]         BINS_RESET = 9'd256;
    localparam logic signed [15:0] LOG10_2_Q16 = 16'sd19728;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    typedef enum logic [1:0] {
        ST_PAINTED = 2'd0,
        ST_NAN     = 2'd1,
        ST_NONPOS  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_VALUE_MIN   = 2'd0,
        CFG_INDEX_SCALE = 2'd1,
        CFG_LOG_MODE    = 2'd2,
        CFG_BINS_IN_USE = 2'd3
    } t_cfg_reg;

    typedef logic [255:0][31:0] t_log_tab;

    // fraction bits of log2(1 + k/256) by repeated squaring in q1.30
    function automatic t_log_tab log2_frac_table(int frac_bits);
        t_log_tab    tab;
        logic [63:0] m;
        logic [31:0] f;
        int          k;
        int          i;
        for (k = 0; k < 256; k++) begin
            m = 64'(256 + k) << 22;
            f = '0;
            for (i = 0; i < frac_bits; i++) begin
                m = (m * m) >> 30;
                f = f << 1;
                if (m >= 64'h0000_0000_8000_0000) begin
                    f[0] = 1'b1;
                    m = m >> 1;
                end
            end
            tab[k] = f;
        end
        return tab;
    endfunction

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [16:0] y;
        logic [16:0] t;
        y = 17'(x) + 17'd1;
        t = y + (y >> 8);
        return t[15:8];
    endfunction

endpackage

FILE: rtl/colormap_alpha_blend.sv
// top level: colormap lookup with alpha blending over a pixel stream
//
// Pixel and load beats enter one per clock while the output is not stalled
// and flow through twelve pipeline stages and the output register; the
// sustained rate is one beat per cycle while no stall holds the pipeline.
// The log unit, the 33 x 32 bit index product (split into four partial
// products over three stages) and the colormap memory with its registered
// read set the depth. Load beats write the colormap at the same stage where
// pixel beats read it, so every pixel sees exactly the loads accepted before
// it; loads give no result. The whole pipeline holds while the output
// register is full and stalled. The colormap has no reset: reading an entry
// never loaded gives an arbitrary color.
module colormap_alpha_blend import cmab_pkg::*; #(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_sample,
    input  logic        i_sample_is_nan,
    input  logic [7:0]  i_old_red,
    input  logic [7:0]  i_old_green,
    input  logic [7:0]  i_old_blue,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_entry_red,
    input  logic [7:0]  i_entry_green,
    input  logic [7:0]  i_entry_blue,
    input  logic [7:0]  i_entry_alpha,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_new_red,
    output logic [7:0]  o_new_green,
    output logic [7:0]  o_new_blue,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW    = $clog2(MAP_ENTRIES);
    localparam int BW    = (IW + 1 > 9) ? IW + 1 : 9;
    localparam int XW    = ((IW > 8) ? IW : 8) + 1;
    localparam int L2W   = FRAC_BITS + 7;
    localparam int QW    = 65 - 2 * FRAC_BITS;
    localparam int NBEAT = 12;
    localparam int S_LOG = 4;
    localparam int S_IDX = 9;
    localparam int S_MEM = 9;
    localparam int S_END = NBEAT - 1;

    typedef struct packed {
        logic        load;
        t_status     status;
        logic [31:0] sample;
        logic [7:0]  old_r;
        logic [7:0]  old_g;
        logic [7:0]  old_b;
        logic [7:0]  eidx;
        logic [31:0] edata;
    } t_beat;

    logic               en;
    t_beat              n_beat;
    logic [NBEAT-1:0]   r_vld;
    t_beat              r_beat [NBEAT];

    logic [31:0]        r_value_min;
    logic [31:0]        r_index_scale;
    logic               r_log_mode;
    logic [8:0]         r_bins;

    logic signed [L2W-1:0] log10_v;
    logic signed [31:0]    v_sel;
    logic signed [32:0]    n_diff;
    logic signed [32:0]    r_diff;

    logic signed [16:0] dh;
    logic signed [16:0] dl_s;
    logic signed [15:0] sh;
    logic signed [16:0] sl_s;
    logic signed [32:0] r_hh;
    logic signed [33:0] r_hl;
    logic signed [32:0] r_lh;
    logic [31:0]        r_ll;
    logic signed [32:0] r_hh2;
    logic [31:0]        r_ll2;
    logic signed [34:0] r_cross;
    logic signed [64:0] r_prod;

    logic [BW-1:0]      bins_ext;
    logic [BW-1:0]      bins_eff;
    logic [IW-1:0]      last_idx;
    logic [QW-1:0]      q;
    logic [IW-1:0]      n_idx;
    logic [IW-1:0]      r_idx;

    logic [31:0]        mem [MAP_ENTRIES];
    logic [XW-1:0]      wr_ext;
    logic               wr_en;
    logic [31:0]        r_rd;

    logic [7:0]         rd_a;
    logic [15:0]        r_x_r;
    logic [15:0]        r_x_g;
    logic [15:0]        r_x_b;

    logic               r_out_valid;
    logic [7:0]         r_new_r;
    logic [7:0]         r_new_g;
    logic [7:0]         r_new_b;
    logic [1:0]         r_status;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_min   <= '0;
            r_index_scale <= 32'(1) << FRAC_BITS;
            r_log_mode    <= 1'b0;
            r_bins        <= BINS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VALUE_MIN:   r_value_min   <= i_cfg_data;
                CFG_INDEX_SCALE: r_index_scale <= i_cfg_data;
                CFG_LOG_MODE:    r_log_mode    <= i_cfg_data[0];
                CFG_BINS_IN_USE: r_bins        <= i_cfg_data[8:0];
                default:         r_bins        <= r_bins;
            endcase
        end
    end

    // input beat and skip status
    always_comb begin
        n_beat.load   = i_action;
        n_beat.sample = i_sample;
        n_beat.old_r  = i_old_red;
        n_beat.old_g  = i_old_green;
        n_beat.old_b  = i_old_blue;
        n_beat.eidx   = i_entry_index;
        n_beat.edata  = {i_entry_red, i_entry_green, i_entry_blue, i_entry_alpha};
        priority if (i_sample_is_nan) begin
            n_beat.status = ST_NAN;
        end else if (r_log_mode && ($signed(i_sample) <= 32'sd0)) begin
            n_beat.status = ST_NONPOS;
        end else begin
            n_beat.status = ST_PAINTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NBEAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_beat[0] <= n_beat;
            for (int i = 1; i < NBEAT; i++) begin
                r_beat[i] <= r_beat[i-1];
            end
        end
    end

    cmab_log10 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_log10 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sample (r_beat[0].sample),
        .o_log10  (log10_v)
    );

    // value minus lower end
    always_comb begin
        if (r_log_mode) begin
            v_sel = {{(32-L2W){log10_v[L2W-1]}}, log10_v};
        end else begin
            v_sel = $signed(r_beat[S_LOG].sample);
        end
        n_diff = {v_sel[31], v_sel} - $signed({r_value_min[31], r_value_min});
    end

    assign dh   = r_diff[32:16];
    assign dl_s = $signed({1'b0, r_diff[15:0]});
    assign sh   = $signed(r_index_scale[31:16]);
    assign sl_s = $signed({1'b0, r_index_scale[15:0]});

    // index product as four partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_diff  <= n_diff;
            r_hh    <= dh * sh;
            r_hl    <= dh * sl_s;
            r_lh    <= dl_s * sh;
            r_ll    <= r_diff[15:0] * r_index_scale[15:0];
            r_hh2   <= r_hh;
            r_ll2   <= r_ll;
            r_cross <= $signed({r_hl[33], r_hl}) + $signed({{2{r_lh[32]}}, r_lh});
            r_prod  <= $signed({r_hh2, r_ll2})
                     + $signed({{14{r_cross[34]}}, r_cross, 16'b0});
        end
    end

    // clamp to the bins in use
    always_comb begin
        bins_ext = BW'(r_bins);
        if (bins_ext == '0) begin
            bins_eff = BW'(1);
        end else if (bins_ext > BW'(MAP_ENTRIES)) begin
            bins_eff = BW'(MAP_ENTRIES);
        end else begin
            bins_eff = bins_ext;
        end
        last_idx = IW'(bins_eff - BW'(1));
        q        = r_prod[64:2*FRAC_BITS];
        priority if (r_prod[64]) begin
            n_idx = '0;
        end else if ((|q[QW-1:IW]) || (q[IW-1:0] > last_idx)) begin
            n_idx = last_idx;
        end else begin
            n_idx = q[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx <= n_idx;
        end
    end

    // colormap: loads write where pixels read
    assign wr_ext = XW'(r_beat[S_MEM].eidx);
    assign wr_en  = r_vld[S_MEM] && (r_beat[S_MEM].load == ACT_LOAD)
                 && (wr_ext < XW'(MAP_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (wr_en) begin
                mem[wr_ext[IW-1:0]] <= r_beat[S_MEM].edata;
            end
            r_rd <= mem[r_idx];
        end
    end

    // blend
    assign rd_a = r_rd[7:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_r <= 16'(r_beat[S_MEM+1].old_r) * 16'(8'd255 - rd_a)
                   + 16'(r_rd[31:24]) * 16'(rd_a);
            r_x_g <= 16'(r_beat[S_MEM+1].old_g) * 16'(8'd255 - rd_a)
                   + 16'(r_rd[23:16]) * 16'(rd_a);
            r_x_b <= 16'(r_beat[S_MEM+1].old_b) * 16'(8'd255 - rd_a)
                   + 16'(r_rd[15:8]) * 16'(rd_a);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[S_END] && (r_beat[S_END].load == ACT_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= r_beat[S_END].status;
            if (r_beat[S_END].status == ST_PAINTED) begin
                r_new_r <= div255(r_x_r);
                r_new_g <= div255(r_x_g);
                r_new_b <= div255(r_x_b);
            end else begin
                r_new_r <= r_beat[S_END].old_r;
                r_new_g <= r_beat[S_END].old_g;
                r_new_b <= r_beat[S_END].old_b;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_red   = r_new_r;
    assign o_new_green = r_new_g;
    assign o_new_blue  = r_new_b;
    assign o_status    = r_status;

    // index stays inside the map
    a_idx_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_IDX] |-> (32'(r_idx) < MAP_ENTRIES))
        else $error("colormap index beyond map");

    // a held result freezes the memory read and the pipeline
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_rd) && $stable(r_vld)))
        else $error("pipeline moved while output held");

endmodule

FILE: rtl/cmab_log10.sv
// pipelined fixed-point base ten logarithm, four register stages
module cmab_log10 import cmab_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [31:0]                 i_sample,
    output logic signed [FRAC_BITS+6:0] o_log10
);

    localparam int       L2W     = FRAC_BITS + 7;
    localparam int       MW      = L2W + 16;
    localparam t_log_tab LOG_TAB = log2_frac_table(FRAC_BITS);

    logic [3:0]       a_nz;
    logic [3:0][2:0]  a_pos;
    logic [3:0]       r_a_nz;
    logic [3:0][2:0]  r_a_pos;
    logic [31:0]      r_a_sample;

    logic [4:0]       b_p;
    logic [31:0]      b_sh;
    logic [4:0]       r_b_p;
    logic [7:0]       r_b_k;

    logic [31:0]           c_entry;
    logic signed [L2W-1:0] c_l2;
    logic signed [L2W-1:0] r_c_l2;
    logic signed [MW-1:0]  r_d_m;

    // leading one inside each byte
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            a_nz[j]  = |i_sample[8*j +: 8];
            a_pos[j] = '0;
            for (int b = 0; b < 8; b++) begin
                if (i_sample[8*j + b]) begin
                    a_pos[j] = 3'(b);
                end
            end
        end
    end

    // highest nonzero byte, then the eight bits below the leading one
    always_comb begin
        b_p = '0;
        for (int j = 0; j < 4; j++) begin
            if (r_a_nz[j]) begin
                b_p = {2'(j), r_a_pos[j]};
            end
        end
        b_sh = r_a_sample << (~b_p);
    end

    always_comb begin
        c_entry = LOG_TAB[r_b_k];
        c_l2    = {7'({2'b00, r_b_p}) - 7'(FRAC_BITS), c_entry[FRAC_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_nz     <= a_nz;
            r_a_pos    <= a_pos;
            r_a_sample <= i_sample;
            r_b_p      <= b_p;
            r_b_k      <= b_sh[30:23];
            r_c_l2     <= c_l2;
            r_d_m      <= r_c_l2 * LOG10_2_Q16;
        end
    end

    assign o_log10 = r_d_m[MW-1:16];

endmodule

FILE: tb/sv/tb_colormap_alpha_blend.sv
// self-checking testbench of colormap_alpha_blend: pixel and colormap load beats against a predictor
module tb_colormap_alpha_blend;
    import cmab_pkg::*;

    localparam int PIPE_LAT = 13;
    localparam int FRAC     = FRAC_BITS_DEF;

    typedef struct packed {
        logic        action;
        logic [31:0] sample_q16;
        logic        is_nan;
        logic [7:0]  old_red, old_green, old_blue;
        logic [7:0]  entry_index, entry_red, entry_green, entry_blue, entry_alpha;
    } t_beat;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_status    status;
    } t_pixel_out;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic        i_action        = ACT_PIXEL;
    logic [31:0] i_sample        = '0;
    logic        i_sample_is_nan = 1'b0;
    logic [7:0]  i_old_red       = '0;
    logic [7:0]  i_old_green     = '0;
    logic [7:0]  i_old_blue      = '0;
    logic [7:0]  i_entry_index   = '0;
    logic [7:0]  i_entry_red     = '0;
    logic [7:0]  i_entry_green   = '0;
    logic [7:0]  i_entry_blue    = '0;
    logic [7:0]  i_entry_alpha   = '0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [7:0]  o_new_red;
    logic [7:0]  o_new_green;
    logic [7:0]  o_new_blue;
    logic [1:0]  o_status;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = '0;
    logic [31:0] i_cfg_data      = '0;

    logic [31:0] colormap_model [MAP_ENTRIES_DEF];
    logic [31:0] map_min       = 32'd0;
    logic [31:0] map_scale     = 32'd1 << FRAC;
    logic        map_log       = 1'b0;
    logic [8:0]  map_bin_count = BINS_RESET;

    t_pixel_out  expected_pixels [$];
    t_pixel_out  due_pixel;
    int          mismatches   = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int          hold_request = 0;
    int          stall_left   = 0;
    int          rx_wait;
    longint      win_base     = 0;
    longint      win_width    = 0;

    colormap_alpha_blend dut (.*);

    initial forever #1 i_clk = ~i_clk;

    initial begin
        #500000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [FRAC-1:0] log2_fraction(logic [7:0] k);
        longint unsigned mant;
        logic [FRAC-1:0] bits;
        mant = (64'(k) + 64'd256) << 22;
        bits = '0;
        for (int i = 0; i < FRAC; i++) begin
            mant = (mant * mant) >> 30;
            bits = bits << 1;
            if (mant >= 64'h8000_0000) begin
                bits[0] = 1'b1;
                mant    = mant >> 1;
            end
        end
        return bits;
    endfunction

    function automatic longint log10_q16(logic [31:0] s);
        int         lead;
        logic [7:0] k;
        longint     l2;
        lead = 0;
        for (int b = 0; b < 32; b++)
            if (s[b]) lead = b;
        k  = (lead >= 8) ? 8'(s >> (lead - 8)) : 8'(s << (8 - lead));
        l2 = longint'(lead - FRAC) * (longint'(1) << FRAC) + longint'(log2_fraction(k));
        return (l2 * longint'(LOG10_2_Q16)) >>> 16;
    endfunction

    function automatic logic [7:0] mix(logic [7:0] old, logic [7:0] c, logic [7:0] a);
        return 8'((int'(old) * (255 - int'(a)) + int'(c) * int'(a)) / 255);
    endfunction

    function automatic t_pixel_out paint_pixel(t_beat b);
        t_pixel_out  res;
        longint      v;
        longint      prod;
        longint      top;
        longint      idx;
        logic [31:0] e;
        res.red    = b.old_red;
        res.green  = b.old_green;
        res.blue   = b.old_blue;
        res.status = ST_PAINTED;
        if (b.is_nan) begin
            res.status = ST_NAN;
            return res;
        end
        v = longint'($signed(b.sample_q16));
        if (map_log) begin
            if (v <= 0) begin
                res.status = ST_NONPOS;
                return res;
            end
            v = log10_q16(b.sample_q16);
        end
        if (map_bin_count == 0) top = 0;
        else if (map_bin_count > MAP_ENTRIES_DEF) top = MAP_ENTRIES_DEF - 1;
        else top = longint'(map_bin_count) - 1;
        prod = (v - longint'($signed(map_min))) * longint'($signed(map_scale));
        idx  = (prod < 0) ? 0 : (prod >>> (2 * FRAC));
        if (idx > top) idx = top;
        e = colormap_model[idx];
        res.red   = mix(b.old_red, e[31:24], e[7:0]);
        res.green = mix(b.old_green, e[23:16], e[7:0]);
        res.blue  = mix(b.old_blue, e[15:8], e[7:0]);
        return res;
    endfunction

    function automatic t_beat pixel_beat(logic [31:0] s, logic nan, logic [7:0] r, g, bl);
        t_beat b;
        b.action      = ACT_PIXEL;
        b.sample_q16  = s;
        b.is_nan      = nan;
        b.old_red     = r;
        b.old_green   = g;
        b.old_blue    = bl;
        b.entry_index = 8'($urandom);
        b.entry_red   = 8'($urandom);
        b.entry_green = 8'($urandom);
        b.entry_blue  = 8'($urandom);
        b.entry_alpha = 8'($urandom);
        return b;
    endfunction

    function automatic t_beat load_beat(logic [7:0] idx, logic [31:0] rgba);
        t_beat b;
        b.action      = ACT_LOAD;
        b.sample_q16  = $urandom;
        b.is_nan      = 1'($urandom);
        b.old_red     = 8'($urandom);
        b.old_green   = 8'($urandom);
        b.old_blue    = 8'($urandom);
        b.entry_index = idx;
        b.entry_red   = rgba[31:24];
        b.entry_green = rgba[23:16];
        b.entry_blue  = rgba[15:8];
        b.entry_alpha = rgba[7:0];
        return b;
    endfunction

    function automatic logic [31:0] random_sample();
        longint s;
        if (map_log) begin
            if ($urandom_range(0, 9) == 0)
                return ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
            return $urandom >> $urandom_range(1, 31);
        end
        if (win_width == 0 || $urandom_range(0, 3) == 0) return $urandom;
        s = win_base - win_width / 8 + longint'($urandom_range(0, 32'(win_width + win_width / 4)));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return 32'(s);
    endfunction

    function automatic t_beat random_beat();
        if ($urandom_range(0, 99) < 15) return load_beat(8'($urandom), $urandom);
        return pixel_beat(random_sample(), $urandom_range(0, 19) == 0,
                          8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %0d: %s got %0d expected %0d", mismatches, what, got, want);
    endtask

    task automatic send_beat(t_beat b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= b.action;
        i_sample        <= b.sample_q16;
        i_sample_is_nan <= b.is_nan;
        i_old_red       <= b.old_red;
        i_old_green     <= b.old_green;
        i_old_blue      <= b.old_blue;
        i_entry_index   <= b.entry_index;
        i_entry_red     <= b.entry_red;
        i_entry_green   <= b.entry_green;
        i_entry_blue    <= b.entry_blue;
        i_entry_alpha   <= b.entry_alpha;
        do @(posedge i_clk); while (o_in_stall);
        if (b.action == ACT_LOAD)
            colormap_model[b.entry_index] = {b.entry_red, b.entry_green, b.entry_blue,
                                             b.entry_alpha};
        else
            expected_pixels.push_back(paint_pixel(b));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (r)
            CFG_VALUE_MIN:   map_min = d;
            CFG_INDEX_SCALE: map_scale = d;
            CFG_LOG_MODE:    map_log = d[0];
            CFG_BINS_IN_USE: map_bin_count = d[8:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] vmin, logic [31:0] scale, logic log_on,
                              logic [8:0] count);
        longint eff;
        write_reg(CFG_VALUE_MIN, vmin);
        write_reg(CFG_INDEX_SCALE, scale);
        write_reg(CFG_LOG_MODE, {31'($urandom), log_on});
        write_reg(CFG_BINS_IN_USE, {23'($urandom), count});
        eff = (count == 0) ? 1 : ((count > MAP_ENTRIES_DEF) ? MAP_ENTRIES_DEF : count);
        win_base = longint'($signed(vmin));
        if ($signed(scale) > 0) win_width = (eff << 32) / longint'($signed(scale));
        else win_width = 0;
        if (win_width > 64'h3FFF_FFFF) win_width = 0;
    endtask

    task automatic random_setup(bit use_log);
        logic [8:0]  count;
        int          eff;
        int          vmin;
        logic [31:0] scale;
        count = 9'($urandom_range(1, 256));
        case ($urandom_range(0, 9))
            0: count = 9'd0;
            1: count = 9'($urandom_range(257, 511));
            2: count = 9'd256;
            default: ;
        endcase
        eff = (count == 0) ? 1 : ((count > 256) ? 256 : int'(count));
        if (use_log) begin
            vmin  = (int'($urandom_range(0, 5)) - 5) * 65536 + int'($urandom_range(0, 65535));
            scale = 32'(eff * 65536 / int'($urandom_range(2, 14)));
        end else begin
            vmin  = int'($urandom) >>> $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) scale = $urandom | 32'h8000_0000;
            else scale = $urandom_range(1 << 10, 1 << 22);
        end
        set_config(vmin, scale, use_log, count);
    endtask

    // receiver: random stall after each result while rx_idle_on is set, or a long hold when asked
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (o_out_valid === 1'b1 && !i_out_stall && rx_idle_on) begin
            rx_wait = $urandom_range(0, 15);
            i_out_stall <= (rx_wait > 0);
            stall_left = (rx_wait > 0) ? rx_wait - 1 : 0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result beat with nothing expected", 1, 0);
            end else begin
                due_pixel = expected_pixels.pop_front();
                if (o_new_red !== due_pixel.red)
                    report_mismatch("new_red", o_new_red, due_pixel.red);
                if (o_new_green !== due_pixel.green)
                    report_mismatch("new_green", o_new_green, due_pixel.green);
                if (o_new_blue !== due_pixel.blue)
                    report_mismatch("new_blue", o_new_blue, due_pixel.blue);
                if (o_status !== due_pixel.status)
                    report_mismatch("status", o_status, int'(due_pixel.status));
            end
        end
    end

    task automatic test_fill_colormap();
        logic [31:0] rgba;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < MAP_ENTRIES_DEF; i++) begin
            rgba = $urandom;
            if (i == 0) rgba = 32'hFFFF_FF00;
            if (i == 1) rgba = 32'h0000_00FF;
            if (i == MAP_ENTRIES_DEF - 1) rgba = 32'hFFFF_FFFF;
            send_beat(load_beat(8'(i), rgba));
        end
        settle();
    endtask

    // runs on the reset register values
    task automatic test_pixel_extremes();
        tx_idle_on = 1'b0;
        send_beat(pixel_beat(32'h0000_0000, 1'b0, 8'h00, 8'hFF, 8'h00));
        send_beat(pixel_beat(32'h0001_0000, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        send_beat(pixel_beat(32'h00FF_0000, 1'b0, 8'h00, 8'h00, 8'h00));
        send_beat(pixel_beat(32'h7FFF_FFFF, 1'b0, 8'h80, 8'h7F, 8'h01));
        send_beat(pixel_beat(32'h8000_0000, 1'b0, 8'hFF, 8'h00, 8'hFF));
        send_beat(pixel_beat(32'hFFFF_FFFF, 1'b0, 8'h12, 8'h34, 8'h56));
        send_beat(pixel_beat(32'h0080_8000, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom)));
        send_beat(pixel_beat($urandom, 1'b1, 8'hAB, 8'hCD, 8'hEF));
        // reload an entry and read it on the very next beat
        send_beat(load_beat(8'd1, 32'h80C0_4080));
        send_beat(pixel_beat(32'h0001_8000, 1'b0, 8'h10, 8'hF0, 8'h55));
        settle();
    endtask

    task automatic test_special_cases();
        tx_idle_on = 1'b1;
        set_config(32'hFFFB_0000, 32'h0012_0000, 1'b1, 9'd256);
        send_beat(pixel_beat(32'h0000_0000, 1'b1, 8'h11, 8'h22, 8'h33));
        send_beat(pixel_beat(32'h0000_0000, 1'b0, 8'h44, 8'h55, 8'h66));
        send_beat(pixel_beat(32'hFFFF_FFFF, 1'b0, 8'h77, 8'h88, 8'h99));
        send_beat(pixel_beat(32'h8000_0000, 1'b0, 8'hAA, 8'hBB, 8'hCC));
        send_beat(pixel_beat(32'h0000_0001, 1'b0, 8'hDD, 8'hEE, 8'hFF));
        send_beat(pixel_beat(32'h7FFF_FFFF, 1'b0, 8'h00, 8'h80, 8'hFF));
        send_beat(pixel_beat(32'h0001_0000, 1'b0, 8'h5A, 8'hA5, 8'h3C));
        send_beat(pixel_beat(32'h0064_0000, 1'b0, 8'hC3, 8'h0F, 8'hF0));
        settle();
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 9'd0);
        send_beat(pixel_beat(32'h7FFF_FFFF, 1'b0, 8'h01, 8'h02, 8'h03));
        send_beat(pixel_beat(32'h8000_0000, 1'b0, 8'hFC, 8'hFD, 8'hFE));
        settle();
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 9'h1FF);
        send_beat(pixel_beat(32'h8000_0000, 1'b0, 8'h20, 8'h40, 8'h60));
        send_beat(pixel_beat(32'h0000_0000, 1'b0, 8'h80, 8'hA0, 8'hC0));
        send_beat(pixel_beat(32'h7FFF_FFFF, 1'b0, 8'hE0, 8'hF0, 8'h08));
        settle();
    endtask

    task automatic test_backpressure();
        set_config(32'h8000_0000, 32'd256, 1'b0, 9'd256);
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 200;
        repeat (64) send_beat(random_beat());
        settle();
        tx_idle_on   = 1'b1;
        hold_request = 60;
        repeat (32) send_beat(random_beat());
        settle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            tx_idle_on = phase[0];
            rx_idle_on = phase[1];
            random_setup(phase == 2 || phase == 5);
            repeat (90) send_beat(random_beat());
            settle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_colormap();
        test_pixel_extremes();
        test_special_cases();
        test_backpressure();
        test_random_traffic();
        if (mismatches == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: colormap_alpha_blend.f
rtl/cmab_pkg.sv
rtl/cmab_log10.sv
rtl/colormap_alpha_blend.sv
tb/sv/tb_colormap_alpha_blend.sv
